@@ sv/svpd_pkg.sv @@
// shared types, constants and sector tables of the space vector pwm duty block
`timescale 1ns / 1ps
`default_nettype none

package svpd_pkg;

   // widths of the internal values
   localparam int PWM_W = 17;           // saturated pwm value, signed
   localparam int PH_W  = 30;           // phase voltage, signed
   localparam int CSR_W = 31;           // widest register

   // pipeline depth of each part
   localparam int PWM_LAT   = 2;
   localparam int MERGE_LAT = 3;
   localparam int PHASE_LAT = 4;
   localparam int LATENCY   = PWM_LAT + MERGE_LAT + PHASE_LAT;

   // register indexes
   localparam logic CSR_SUPPLY_MV    = 1'b0;
   localparam logic CSR_SUPPLY_RECIP = 1'b1;

   // reset values of the registers
   localparam logic [15:0] SUPPLY_MV_RST    = 16'd24000;
   localparam logic [30:0] SUPPLY_RECIP_RST = 31'd89478;

   // pwm saturation bounds
   localparam int PWM_MAX = 4095 << 4;
   localparam int PWM_MIN = -(4096 << 4);

   // inverse clarke: alpha is scaled by 2048, and the beta path
   // ((b * 2048) >> 6) * 887 >> 4 is exact, i.e. b * 887 * 2
   localparam int ALPHA_SHIFT    = 11;
   localparam int SQRT3_HALF_Q10 = 887;
   localparam int BETA_GAIN      = SQRT3_HALF_Q10 * 2;

   // output scaling
   localparam int GAIN_Q7    = 153;
   localparam int MID_OFFSET = 1 << 27;
   localparam int FULL_SCALE = 8192 << 15;

   // phase selectors
   localparam logic [1:0] PH_A = 2'd0;
   localparam logic [1:0] PH_B = 2'd1;
   localparam logic [1:0] PH_C = 2'd2;

   typedef struct packed {
      logic [15:0] supply_mv;
      logic [30:0] supply_reciprocal;
   } cfg_type;

   typedef struct packed {
      logic signed [PH_W-1:0] ph_a;
      logic signed [PH_W-1:0] ph_b;
      logic signed [PH_W-1:0] ph_c;
      logic signed [PH_W-1:0] vcom;
   } phase_set_type;

   // lowest phase for a sector code; impossible codes pick phase a
   function automatic logic [1:0] low_sel(input logic [2:0] code);
      logic [1:0] sel;
      unique case (code)
         3'd1:    sel = PH_B;
         3'd2:    sel = PH_C;
         3'd3:    sel = PH_C;
         3'd5:    sel = PH_B;
         default: sel = PH_A;
      endcase
      return sel;
   endfunction

   // highest phase for a sector code; impossible codes pick phase a
   function automatic logic [1:0] high_sel(input logic [2:0] code);
      logic [1:0] sel;
      unique case (code)
         3'd2:    sel = PH_B;
         3'd4:    sel = PH_C;
         3'd5:    sel = PH_C;
         3'd6:    sel = PH_B;
         default: sel = PH_A;
      endcase
      return sel;
   endfunction

endpackage

`default_nettype wire

@@ sv/svpd_pwm_lane.sv @@
// one axis lane: saturate at half supply and scale by the supply reciprocal
`timescale 1ns / 1ps
`default_nettype none

module svpd_pwm_lane
   import svpd_pkg::*;
(
   input  wire logic                    clock,
   input  wire cfg_type                 cfg,
   input  wire logic signed [PWM_W-1:0] volt_mv,
   output logic signed [PWM_W-1:0]      pwm
);

   localparam int PROD_W = PWM_W + 32;

   logic signed [PWM_W:0]    volt_ext;
   logic signed [PWM_W:0]    half_ext;
   logic                     sat_hi_in, sat_hi_ff;
   logic                     sat_lo_in, sat_lo_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [PROD_W-1:0] shifted;
   logic signed [PWM_W-1:0]  pwm_in, pwm_ff;

   // saturation test against half the supply
   assign volt_ext  = {volt_mv[PWM_W-1], volt_mv};
   assign half_ext  = $signed({3'b000, cfg.supply_mv[15:1]});
   assign sat_hi_in = volt_ext >= half_ext;
   assign sat_lo_in = volt_ext <= -half_ext;

   // reciprocal product
   assign prod_in = volt_mv * $signed({1'b0, cfg.supply_reciprocal});

   always_ff @(posedge clock) begin
      sat_hi_ff <= sat_hi_in;
      sat_lo_ff <= sat_lo_in;
      prod_ff   <= prod_in;
   end

   // floor shift and clamp to the pwm range
   assign shifted = prod_ff >>> 14;

   always_comb begin
      priority if (sat_hi_ff) begin
         pwm_in = PWM_W'(PWM_MAX);
      end else if (sat_lo_ff) begin
         pwm_in = PWM_W'(PWM_MIN);
      end else if (shifted > PWM_MAX) begin
         pwm_in = PWM_W'(PWM_MAX);
      end else if (shifted < PWM_MIN) begin
         pwm_in = PWM_W'(PWM_MIN);
      end else begin
         pwm_in = shifted[PWM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pwm_ff <= pwm_in;
   end

   assign pwm = pwm_ff;

endmodule

`default_nettype wire

@@ sv/svpd_merge.sv @@
// inverse clarke transform and min-max common mode of the three phases
`timescale 1ns / 1ps
`default_nettype none

module svpd_merge
   import svpd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic signed [PWM_W-1:0] pwm_alpha,
   input  wire logic signed [PWM_W-1:0] pwm_beta,
   output phase_set_type                phases
);

   localparam logic signed [11:0] BETA_K = 12'(BETA_GAIN);

   logic signed [PH_W-1:0] alpha_in, alpha_ff;
   logic signed [PH_W-1:0] neg_half_in, neg_half_ff;
   logic signed [PH_W-1:0] beta_term_in, beta_term_ff;
   logic signed [PH_W-1:0] ph_a_ff, ph_b_ff, ph_c_ff;
   logic [2:0]             code;
   logic signed [PH_W-1:0] ph_lo, ph_hi;
   logic signed [PH_W:0]   mid_sum;
   phase_set_type          phases_in, phases_ff;

   // scaled alpha, minus half alpha, and the beta term
   assign alpha_in     = $signed({{(PH_W-PWM_W-ALPHA_SHIFT){pwm_alpha[PWM_W-1]}},
                                  pwm_alpha, {ALPHA_SHIFT{1'b0}}});
   assign neg_half_in  = -$signed({{(PH_W-PWM_W-ALPHA_SHIFT+1){pwm_alpha[PWM_W-1]}},
                                   pwm_alpha, {(ALPHA_SHIFT-1){1'b0}}});
   assign beta_term_in = pwm_beta * BETA_K;

   always_ff @(posedge clock) begin
      alpha_ff     <= alpha_in;
      neg_half_ff  <= neg_half_in;
      beta_term_ff <= beta_term_in;
   end

   // phase voltages
   always_ff @(posedge clock) begin
      ph_a_ff <= alpha_ff;
      ph_b_ff <= neg_half_ff + beta_term_ff;
      ph_c_ff <= neg_half_ff - beta_term_ff;
   end

   // sector code and extreme phases
   assign code = {ph_c_ff > ph_a_ff, ph_b_ff >= ph_c_ff, ph_a_ff >= ph_b_ff};

   always_comb begin
      unique case (low_sel(code))
         PH_B:    ph_lo = ph_b_ff;
         PH_C:    ph_lo = ph_c_ff;
         default: ph_lo = ph_a_ff;
      endcase
      unique case (high_sel(code))
         PH_B:    ph_hi = ph_b_ff;
         PH_C:    ph_hi = ph_c_ff;
         default: ph_hi = ph_a_ff;
      endcase
   end

   // common mode is the floored midpoint
   assign mid_sum = {ph_lo[PH_W-1], ph_lo} + {ph_hi[PH_W-1], ph_hi};

   always_comb begin
      phases_in.ph_a = ph_a_ff;
      phases_in.ph_b = ph_b_ff;
      phases_in.ph_c = ph_c_ff;
      phases_in.vcom = mid_sum[PH_W:1];
   end

   always_ff @(posedge clock) begin
      phases_ff <= phases_in;
   end

   assign phases = phases_ff;

endmodule

`default_nettype wire

@@ sv/svpd_phase_lane.sv @@
// one phase lane: remove common mode, scale, clamp and form the compare value
`timescale 1ns / 1ps
`default_nettype none

module svpd_phase_lane
   import svpd_pkg::*;
#(
   parameter int PWM_PERIOD = 1004
) (
   input  wire logic                   clock,
   input  wire logic signed [PH_W-1:0] ph,
   input  wire logic signed [PH_W-1:0] vcom,
   output logic [9:0]                  compare
);

   localparam int PERIOD_W = $clog2(PWM_PERIOD + 1);
   localparam int LEVEL_W  = 29;
   localparam int PROD_W   = (LEVEL_W - 10) + PERIOD_W;
   localparam int DUTY_W   = PROD_W - 18;
   localparam logic [PERIOD_W-1:0] PERIOD = PERIOD_W'(PWM_PERIOD);

   logic signed [PH_W:0]      diff;
   logic signed [32:0]        scaled_in, scaled_ff;
   logic signed [33:0]        biased;
   logic [LEVEL_W-1:0]        level_in, level_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [DUTY_W-1:0]         duty;
   logic [16:0]               cmp_full;
   logic [9:0]                compare_ff;

   // phase minus common mode, floored by 128, times the gain
   assign diff      = {ph[PH_W-1], ph} - {vcom[PH_W-1], vcom};
   assign scaled_in = $signed(diff[PH_W:7]) * $signed(9'(GAIN_Q7));

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
   end

   // offset to unsigned and clamp to full scale
   assign biased = {scaled_ff[32], scaled_ff} + 34'(MID_OFFSET);

   always_comb begin
      priority if (biased > FULL_SCALE) begin
         level_in = LEVEL_W'(FULL_SCALE);
      end else if (biased < 0) begin
         level_in = '0;
      end else begin
         level_in = biased[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   // duty in timer ticks
   always_ff @(posedge clock) begin
      prod_ff <= level_ff[LEVEL_W-1:10] * PERIOD;
   end

   // center-aligned compare is period minus duty
   assign duty     = prod_ff[PROD_W-1:18];
   assign cmp_full = 17'(PWM_PERIOD) - 17'(duty);

   always_ff @(posedge clock) begin
      compare_ff <= cmp_full[9:0];
   end

   assign compare = compare_ff;

endmodule

`default_nettype wire

@@ sv/space_vector_pwm_duty.sv @@
// top level of the space vector pwm duty generator
`timescale 1ns / 1ps
`default_nettype none

// Takes one alpha/beta voltage pair per clock and returns three center-aligned
// timer compare values (period minus duty) with min-max common-mode injection.
// An item is taken on any clock edge where start is high and busy is low; busy
// is only high while reset is held. Every item yields exactly one result,
// shown for one cycle with rsp_valid; the receiver cannot stall, so results
// must be captured when the strobe is seen. The pipeline registers sit in the
// axis lanes (saturation and reciprocal product, then clamp), the merge
// (inverse Clarke, phase sums, common mode) and the phase lanes (gain
// product, clamp, period product, subtract). Registers supply_mv and
// supply_reciprocal may be written at any time the pipeline holds no item.

module space_vector_pwm_duty
   import svpd_pkg::*;
#(
   parameter int PWM_PERIOD = 1004
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [PWM_W-1:0] req_alpha_mv,
   input  wire logic signed [PWM_W-1:0] req_beta_mv,
   output logic                         rsp_valid,
   output logic [9:0]                   rsp_compare_a,
   output logic [9:0]                   rsp_compare_b,
   output logic [9:0]                   rsp_compare_c,
   input  wire logic                    csr_we,
   input  wire logic                    csr_index,
   input  wire logic [CSR_W-1:0]        csr_wdata
);

   cfg_type                 cfg_in, cfg_ff;
   logic                    accept;
   logic [LATENCY-1:0]      valid_in, valid_ff;
   logic signed [PWM_W-1:0] pwm_alpha, pwm_beta;
   phase_set_type           phases;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SUPPLY_MV:    cfg_in.supply_mv = csr_wdata[15:0];
            CSR_SUPPLY_RECIP: cfg_in.supply_reciprocal = csr_wdata[30:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.supply_mv         <= SUPPLY_MV_RST;
         cfg_ff.supply_reciprocal <= SUPPLY_RECIP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // item tracking through the pipeline
   assign busy     = reset;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LATENCY-1];

   // axis lanes
   svpd_pwm_lane u_lane_alpha (
      .clock   (clock),
      .cfg     (cfg_ff),
      .volt_mv (req_alpha_mv),
      .pwm     (pwm_alpha)
   );

   svpd_pwm_lane u_lane_beta (
      .clock   (clock),
      .cfg     (cfg_ff),
      .volt_mv (req_beta_mv),
      .pwm     (pwm_beta)
   );

   // phases and common mode
   svpd_merge u_merge (
      .clock     (clock),
      .pwm_alpha (pwm_alpha),
      .pwm_beta  (pwm_beta),
      .phases    (phases)
   );

   // phase lanes
   svpd_phase_lane #(.PWM_PERIOD(PWM_PERIOD)) u_phase_a (
      .clock   (clock),
      .ph      (phases.ph_a),
      .vcom    (phases.vcom),
      .compare (rsp_compare_a)
   );

   svpd_phase_lane #(.PWM_PERIOD(PWM_PERIOD)) u_phase_b (
      .clock   (clock),
      .ph      (phases.ph_b),
      .vcom    (phases.vcom),
      .compare (rsp_compare_b)
   );

   svpd_phase_lane #(.PWM_PERIOD(PWM_PERIOD)) u_phase_c (
      .clock   (clock),
      .ph      (phases.ph_c),
      .vcom    (phases.vcom),
      .compare (rsp_compare_c)
   );

endmodule

`default_nettype wire

@@ sv/svpd_checker.sv @@
// port-level checks of the space vector pwm duty generator, bound to the top
`timescale 1ns / 1ps
`default_nettype none

module svpd_checker
   import svpd_pkg::*;
#(
   parameter int PWM_PERIOD = 1004
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire logic                    rsp_valid,
   input wire logic [9:0]              rsp_compare_a,
   input wire logic [9:0]              rsp_compare_b,
   input wire logic [9:0]              rsp_compare_c
);

   // every accepted item gives a result after the fixed latency
   a_item_gives_result: assert property (
      @(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid
   ) else $error("accepted item produced no result");

   // no result without an item accepted the fixed latency earlier
   a_result_has_item: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY)
   ) else $error("result without a matching item");

   // compare values never exceed the period; checked only when the period fits in ten bits
   a_compare_range: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (PWM_PERIOD > 1023) ||
                    (rsp_compare_a <= PWM_PERIOD && rsp_compare_b <= PWM_PERIOD &&
                     rsp_compare_c <= PWM_PERIOD)
   ) else $error("compare value above the period");

endmodule

bind space_vector_pwm_duty svpd_checker #(.PWM_PERIOD(PWM_PERIOD)) u_svpd_checker (.*);

`default_nettype wire
